[design/rwf_pkg.sv]
// ----------------------------------------------------------------------------
// rwf_pkg
// Shared types and constants for the replay window filter.
// ----------------------------------------------------------------------------
package rwf_pkg;

    localparam int SEQ_W = 64;
    localparam int GAP_W = 32;
    localparam int OP_W  = 2;

    localparam logic [GAP_W-1:0] GAP_RESET  = 32'd1024;
    localparam logic [SEQ_W-1:0] SEND_RESET = 64'd1;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK    = 2'd0,
        OP_ACCEPT   = 2'd1,
        OP_GET_NEXT = 2'd2
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SEQ_W-1:0] seq;
    } rwf_req_t;

    typedef struct packed {
        logic             passes;
        logic [SEQ_W-1:0] send;
    } rwf_rsp_t;

endpackage

[design/rwf_if.sv]
// ----------------------------------------------------------------------------
// rwf_if
// Valid/ready channels for requests and results of the replay window filter.
// ----------------------------------------------------------------------------
interface rwf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] seq_number;

    modport source (output valid, output operation, output seq_number, input ready);
    modport sink   (input valid, input operation, input seq_number, output ready);
endinterface

interface rwf_rsp_if;
    logic        valid;
    logic        ready;
    logic        passes;
    logic [63:0] send_number;

    modport source (output valid, output passes, output send_number, input ready);
    modport sink   (input valid, input passes, input send_number, output ready);
endinterface

[design/rwf_in_stage.sv]
// ----------------------------------------------------------------------------
// rwf_in_stage
// Input register: holds one request until the window logic consumes it.
// ----------------------------------------------------------------------------
module rwf_in_stage
    import rwf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    rwf_req_if.sink  req,
    input  logic     advance,
    output logic     held_valid,
    output rwf_req_t held
);

    logic     valid_reg;
    logic     valid_next;
    rwf_req_t data_reg;
    logic     load;

    assign req.ready  = !valid_reg || advance;
    assign load       = req.valid && req.ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.op  <= req.operation;
            data_reg.seq <= req.seq_number;
        end
    end

    assign held_valid = valid_reg;
    assign held       = data_reg;

endmodule

[design/rwf_window.sv]
// ----------------------------------------------------------------------------
// rwf_window
// Window state, gap register and the single-pass check/mark/counter logic.
// ----------------------------------------------------------------------------
module rwf_window
    import rwf_pkg::*;
#(
    parameter int WINDOW_SIZE = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [GAP_W-1:0] cfg_wdata,
    input  logic             fire,
    input  rwf_req_t         req,
    output rwf_rsp_t         rsp
);

    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam logic [SEQ_W-1:0] WIN_LEN  = SEQ_W'(WINDOW_SIZE);
    localparam logic [SEQ_W-1:0] WIN_TOP  = SEQ_W'(WINDOW_SIZE - 1);
    localparam logic [IDX_W-1:0] TOP_IDX  = IDX_W'(WINDOW_SIZE - 1);

    logic [GAP_W-1:0]       gap_reg;
    logic [SEQ_W-1:0]       base_reg;
    logic [SEQ_W-1:0]       base_next;
    logic [WINDOW_SIZE-1:0] marks_reg;
    logic [WINDOW_SIZE-1:0] marks_next;
    logic [SEQ_W-1:0]       send_reg;
    logic [SEQ_W-1:0]       send_next;

    op_t              op;
    logic             below;
    logic [SEQ_W-1:0] offset;
    logic             beyond;
    logic             too_far;
    logic             slide;
    logic [IDX_W-1:0] idx;
    logic             pass;

    assign op      = op_t'(req.op);
    assign below   = req.seq < base_reg;
    assign offset  = req.seq - base_reg;
    assign beyond  = offset >= WIN_LEN;
    assign too_far = (offset[SEQ_W-1:GAP_W] != '0) || (offset[GAP_W-1:0] > gap_reg);
    assign slide   = !below && beyond && !too_far;
    assign idx     = beyond ? TOP_IDX : offset[IDX_W-1:0];
    assign pass    = !below && (beyond ? !too_far : !marks_reg[idx]);

    always_comb
    begin
        base_next  = base_reg;
        marks_next = marks_reg;
        send_next  = send_reg;
        rsp.passes = 1'b0;
        rsp.send   = '0;
        unique case (op)
            OP_CHECK:
            begin
                rsp.passes = pass;
                if (slide)
                begin
                    base_next  = req.seq - WIN_TOP;
                    marks_next = '0;
                end
            end
            OP_ACCEPT:
            begin
                rsp.passes = pass;
                if (slide)
                begin
                    base_next  = req.seq - WIN_TOP;
                    marks_next = '0;
                end
                if (pass)
                begin
                    marks_next[idx] = 1'b1;
                    if (req.seq >= send_reg)
                    begin
                        send_next = req.seq + SEQ_W'(1);
                    end
                end
            end
            OP_GET_NEXT:
            begin
                rsp.send  = send_reg;
                send_next = send_reg + SEQ_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg   <= GAP_RESET;
            base_reg  <= '0;
            marks_reg <= '0;
            send_reg  <= SEND_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                gap_reg <= cfg_wdata;
            end
            if (fire)
            begin
                base_reg  <= base_next;
                marks_reg <= marks_next;
                send_reg  <= send_next;
            end
        end
    end

endmodule

[design/rwf_out_stage.sv]
// ----------------------------------------------------------------------------
// rwf_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module rwf_out_stage
    import rwf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  rwf_rsp_t  result,
    output logic      free,
    rwf_rsp_if.source rsp
);

    logic     valid_reg;
    logic     valid_next;
    rwf_rsp_t data_reg;

    assign free       = !valid_reg || rsp.ready;
    assign valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.passes      = data_reg.passes;
    assign rsp.send_number = data_reg.send;

endmodule

[design/replay_window_filter.sv]
// ----------------------------------------------------------------------------
// replay_window_filter
// Sliding-window anti-replay check with next-send counter.
//
//   channel | dir | payload                          | handshake
//   req     | in  | operation[1:0], seq_number[63:0] | valid/ready
//   rsp     | out | passes, send_number[63:0]        | valid/ready
//   cfg     | in  | cfg_wdata[31:0] (max_ahead_gap)  | cfg_we
//
// One request per cycle sustained while rsp is ready; each request passes
// through the input register, then the result register. Window state
// updates in the cycle a request leaves the input register. Reset clears
// state at once, no sweep. A stalled rsp holds the result; req stays
// ready while the input register is empty or draining.
// ----------------------------------------------------------------------------
module replay_window_filter
    import rwf_pkg::*;
#(
    parameter int WINDOW_SIZE = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    rwf_req_if.sink          req,
    rwf_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [GAP_W-1:0] cfg_wdata
);

    logic     held_valid;
    rwf_req_t held;
    logic     out_free;
    logic     advance;
    rwf_rsp_t result;

    assign advance = held_valid && out_free;

    rwf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    rwf_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .req       (held),
        .rsp       (result)
    );

    rwf_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .free   (out_free),
        .rsp    (rsp)
    );

`ifndef SYNTH
    a_held_kept: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && !advance |=> held_valid)
        else $error("held request dropped");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp.valid)
        else $error("consumed request left no result");

    a_pass_no_send: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.passes |-> rsp.send_number == '0)
        else $error("passing result carries send number");
`endif

endmodule

[tb/replay_window_filter_test.sv]
// ----------------------------------------------------------------------------
// replay_window_filter_test
// Self-checking bench for the anti-replay window filter: directed corner
// requests, then random traffic under several gap limits, with random stalls
// on both channels and an in-bench model of the window, marks and counter.
// ----------------------------------------------------------------------------
module replay_window_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rwf_pkg::*;

    localparam int WIN = 64;
    localparam int WIN_IDX_W = $clog2(WIN);
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [GAP_W-1:0] cfg_wdata;

    rwf_req_if req_ch ();
    rwf_rsp_if rsp_ch ();

    replay_window_filter #(
        .WINDOW_SIZE (WIN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // model state
    logic [SEQ_W-1:0] win_base  = '0;
    logic [WIN-1:0]   seen_bits = '0;
    logic [SEQ_W-1:0] send_ctr  = SEND_RESET;
    logic [GAP_W-1:0] gap_limit = GAP_RESET;

    rwf_rsp_t verdict_q[$];
    rwf_rsp_t want;
    int       fail_cnt  = 0;
    int       cycle_cnt = 0;
    int       rsp_hold  = 0;
    bit       req_steady = 1'b0;
    bit       rsp_steady = 1'b0;

    always #10 clk = ~clk;

    function automatic void log_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic bit window_admits(input logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] offset;
        if (seq < win_base)
        begin
            return 1'b0;
        end
        offset = seq - win_base;
        if (offset >= 64'(WIN))
        begin
            if (offset > {32'd0, gap_limit})
            begin
                return 1'b0;
            end
            win_base  = seq - 64'(WIN) + 64'd1;
            seen_bits = '0;
            offset    = 64'(WIN - 1);
        end
        return !seen_bits[offset[WIN_IDX_W-1:0]];
    endfunction

    function automatic rwf_rsp_t predict_result(input logic [OP_W-1:0] op,
                                                input logic [SEQ_W-1:0] seq);
        rwf_rsp_t         r;
        logic [SEQ_W-1:0] offset;
        r = '0;
        case (op)
            OP_CHECK:
            begin
                r.passes = window_admits(seq);
            end
            OP_ACCEPT:
            begin
                if (window_admits(seq))
                begin
                    r.passes = 1'b1;
                    offset = seq - win_base;
                    if (offset < 64'(WIN))
                    begin
                        seen_bits[offset[WIN_IDX_W-1:0]] = 1'b1;
                    end
                    if (seq >= send_ctr)
                    begin
                        send_ctr = seq + 64'd1;
                    end
                end
            end
            OP_GET_NEXT:
            begin
                r.send   = send_ctr;
                send_ctr = send_ctr + 64'd1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq);
        int gap;
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.seq_number <= seq;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        verdict_q.push_back(predict_result(op, seq));
        gap = 0;
        if (!req_steady && $urandom_range(0, 2) == 0)
        begin
            gap = gap_length();
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_gap_limit(input logic [GAP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gap_limit = value;
    endtask

    task automatic random_request();
        int               r;
        logic [OP_W-1:0]  op;
        logic [SEQ_W-1:0] seq;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = OP_ACCEPT;
        else if (r < 85)
            op = OP_CHECK;
        else if (r < 97)
            op = OP_GET_NEXT;
        else
            op = OP_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 10)
            seq = win_base - 64'($urandom_range(1, 8));
        else if (r < 70)
            seq = win_base + 64'($urandom_range(0, WIN - 1));
        else if (r < 82)
            seq = win_base + 64'($urandom_range(WIN, 3 * WIN));
        else if (r < 94)
            seq = win_base + {32'd0, gap_limit} + 64'($urandom_range(0, 2)) - 64'd1;
        else
            seq = {$urandom, $urandom};
        send_request(op, seq);
    endtask

    task automatic test_reset_state();
        send_request(OP_GET_NEXT, 64'd0);
        send_request(OP_CHECK, 64'd0);
        send_request(OP_ACCEPT, 64'd0);
        send_request(OP_CHECK, 64'd0);
        send_request(OP_ACCEPT, 64'd0);
        send_request(OP_GET_NEXT, SEQ_MAX);
    endtask

    task automatic test_window_edges();
        send_request(OP_ACCEPT, 64'd63);
        send_request(OP_CHECK, 64'd63);
        send_request(OP_CHECK, 64'd64);
        send_request(OP_CHECK, 64'd63);
        send_request(OP_CHECK, 64'd0);
        send_request(OP_CHECK, win_base + {32'd0, gap_limit});
        send_request(OP_CHECK, win_base + {32'd0, gap_limit} + 64'd1);
        send_request(OP_CHECK, SEQ_MAX);
        send_request(OP_UNUSED, SEQ_MAX);
        send_request(OP_GET_NEXT, 64'd0);
    endtask

    task automatic test_gap_extremes();
        wait_drained();
        write_gap_limit('0);
        send_request(OP_CHECK, win_base + 64'(WIN));
        send_request(OP_ACCEPT, win_base + 64'd5);
        wait_drained();
        write_gap_limit('1);
        send_request(OP_ACCEPT, win_base + 64'hFFFF_FFFF);
        send_request(OP_ACCEPT, SEQ_MAX);
        send_request(OP_CHECK, win_base + 64'h1_0000_0000);
        send_request(OP_GET_NEXT, 64'd0);
    endtask

    task automatic test_random_traffic();
        logic [GAP_W-1:0] limit;
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       limit = GAP_W'($urandom_range(0, 200));
                1:       limit = GAP_RESET;
                2:       limit = '0;
                3:       limit = '1;
                default: limit = $urandom;
            endcase
            wait_drained();
            write_gap_limit(limit);
            req_steady = (p == 2);
            rsp_steady = (p == 2);
            repeat (160) random_request();
        end
        req_steady = 1'b0;
        rsp_steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_hold = rsp_hold - 1;
        end
        else if (!rsp_steady && $urandom_range(0, 3) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold = gap_length();
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (verdict_q.size() == 0)
            begin
                log_failure($sformatf("unexpected result: passes %0b send %h",
                                      rsp_ch.passes, rsp_ch.send_number));
            end
            else
            begin
                want = verdict_q.pop_front();
                if (rsp_ch.passes !== want.passes || rsp_ch.send_number !== want.send)
                begin
                    log_failure($sformatf(
                        "mismatch: expected passes %0b send %h, got passes %0b send %h",
                        want.passes, want.send, rsp_ch.passes, rsp_ch.send_number));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_CHECK;
        req_ch.seq_number <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_window_edges();
        test_gap_extremes();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            log_failure($sformatf("%0d results never arrived", verdict_q.size()));
        end
        if (fail_cnt == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
design/rwf_pkg.sv
design/rwf_if.sv
design/rwf_in_stage.sv
design/rwf_window.sv
design/rwf_out_stage.sv
design/replay_window_filter.sv
tb/replay_window_filter_test.sv
